@@ src/bcmd_pkg.sv @@
`timescale 1ns / 1ps
package bcmd_pkg;

  localparam logic [7:0] ACK_BYTE  = 8'h79;
  localparam logic [7:0] NACK_BYTE = 8'h1F;
  localparam logic [7:0] SYNC_BYTE = 8'h7F;
  localparam logic [7:0] ERASE_ALL = 8'hFF;
  localparam logic [7:0] GET_COUNT = 8'h07;
  localparam logic [7:0] ID_COUNT  = 8'h01;

  localparam logic [7:0] C_GET   = 8'h00;
  localparam logic [7:0] C_GETV  = 8'h01;
  localparam logic [7:0] C_GETID = 8'h02;
  localparam logic [7:0] C_READ  = 8'h11;
  localparam logic [7:0] C_GO    = 8'h21;
  localparam logic [7:0] C_WRITE = 8'h31;
  localparam logic [7:0] C_ERASE = 8'h43;

  localparam logic [2:0] K_SERIAL = 3'd0;
  localparam logic [2:0] K_ERASE  = 3'd1;
  localparam logic [2:0] K_GLOBAL = 3'd2;
  localparam logic [2:0] K_WRITE  = 3'd3;
  localparam logic [2:0] K_READ   = 3'd4;
  localparam logic [2:0] K_JUMP   = 3'd5;

  localparam logic [7:0] REG_VERSION = 8'd0;
  localparam logic [7:0] REG_PRODUCT = 8'd1;

  localparam int SER_MAX = 11;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_READ,
    ACT_GLOBAL,
    ACT_JUMP,
    ACT_CHUNK
  } act_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic [31:0] address;
    logic [8:0]  read_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic emit;
    logic release_hold;
  } ctl_t;

  typedef struct packed {
    logic emit_ok;
    logic release_ok;
    logic hold_valid;
  } stat_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [63:0] payload,
                                  logic [3:0] cnt, logic [31:0] addr,
                                  logic [8:0] rlen);
    res_t r;
    r.kind        = kind;
    r.payload     = payload;
    r.byte_count  = cnt;
    r.address     = addr;
    r.read_length = rlen;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

@@ src/bcmd_if.sv @@
`timescale 1ns / 1ps
interface bcmd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bcmd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] payload;
  logic [3:0]  byte_count;
  logic [31:0] address;
  logic [8:0]  read_length;
  logic        last;

  modport source (output valid, output kind, output payload, output byte_count,
                  output address, output read_length, output last, input ready);
  modport sink (input valid, input kind, input payload, input byte_count,
                input address, input read_length, input last, output ready);
endinterface

@@ src/bcmd_ram.sv @@
`timescale 1ns / 1ps
module bcmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/bcmd_out.sv @@
`timescale 1ns / 1ps
module bcmd_out (
  input  logic             clk,
  input  logic             rst,
  input  bcmd_pkg::ctl_t   ctl,
  input  bcmd_pkg::res_t   res_in,
  output bcmd_pkg::stat_t  stat,
  bcmd_res_if.source       res
);
  import bcmd_pkg::*;

  res_t hold_r;
  res_t rel_r;
  res_t out_r;
  logic hold_v;
  logic out_v;
  logic out_free;

  assign out_free        = !out_v || res.ready;
  assign stat.emit_ok    = !hold_v || out_free;
  assign stat.release_ok = out_free;
  assign stat.hold_valid = hold_v;

  always_comb begin
    rel_r      = hold_r;
    rel_r.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (ctl.emit) begin
      hold_r <= res_in;
      hold_v <= 1'b1;
      if (hold_v) begin
        out_r <= hold_r;
        out_v <= 1'b1;
      end else if (out_v && res.ready) begin
        out_v <= 1'b0;
      end
    end else if (ctl.release_hold) begin
      out_r  <= rel_r;
      out_v  <= 1'b1;
      hold_v <= 1'b0;
    end else if (out_v && res.ready) begin
      out_v <= 1'b0;
    end
  end

  assign res.valid       = out_v;
  assign res.kind        = out_r.kind;
  assign res.payload     = out_r.payload;
  assign res.byte_count  = out_r.byte_count;
  assign res.address     = out_r.address;
  assign res.read_length = out_r.read_length;
  assign res.last        = out_r.last;

  a_release_needs_hold: assert property (@(posedge clk) disable iff (rst)
    ctl.release_hold |-> hold_v)
    else $error("release without held result");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && hold_v) |-> out_free)
    else $error("result overwritten before transfer");
  a_release_last: assert property (@(posedge clk) disable iff (rst)
    ctl.release_hold |=> (out_v && out_r.last))
    else $error("released result not marked last");
endmodule

@@ src/uart_bootloader_command_engine.sv @@
`timescale 1ns / 1ps
// Target-side command engine of a UART serial bootloader. One received byte
// is taken at a time; rx.ready is low while the results of the previous byte
// are being produced. Each byte is stored (S_IDLE) and decoded (S_DECIDE);
// then each queued serial reply byte (at most 11) is packed, and for write
// chunks and page erases each data byte is read from the receive store
// through S_CHK_RD and S_CHK_ACC (the store has a single read port with
// registered data). The result sink can stall packing and read-back.
// Serial replies are packed up to 8 bytes per result; the final result of
// each byte carries last. The receive store needs no clearing after reset.
module uart_bootloader_command_engine #(
  parameter int RX_STORE_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  bcmd_rx_if.sink     rx,
  bcmd_res_if.source  res,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bcmd_pkg::*;

  localparam int IW = $clog2(RX_STORE_BYTES);
  localparam int CW = $clog2(RX_STORE_BYTES + 1);
  localparam int LW = (CW > 10) ? CW : 10;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_DECIDE  = 8'b00000010,
    S_SER_A   = 8'b00000100,
    S_ACT     = 8'b00001000,
    S_CHK_RD  = 8'b00010000,
    S_CHK_ACC = 8'b00100000,
    S_SER_B   = 8'b01000000,
    S_FIN     = 8'b10000000
  } state_t;

  state_t      state;
  logic [CW-1:0] rx_count;
  logic        in_cmd;
  logic [7:0]  cmd;
  logic [7:0]  hdr [7];
  logic [7:0]  xor0;
  logic [7:0]  xor5;
  logic [7:0]  version_byte;
  logic [15:0] product_id;

  logic [7:0]  a_buf [SER_MAX];
  logic [3:0]  a_len;
  logic [3:0]  a_i;
  act_t        act;
  logic        b_ack;
  logic [2:0]  ck_kind;
  logic [2:0]  ck_start;
  logic [8:0]  ck_n;
  logic [8:0]  ck_pos;
  logic [8:0]  ck_off;
  logic [2:0]  ck_j;
  logic [63:0] ck_buf;
  logic [31:0] base;
  logic [8:0]  rd_len;

  logic [63:0] pend;
  logic [3:0]  pend_n;

  logic        fire;
  logic [IW-1:0] wr_idx;
  logic [7:0]  ram_rdata;
  logic [IW-1:0] ram_raddr;

  // decode outputs
  logic        d_restart;
  logic        d_to_data;
  logic        d_set_cmd;
  logic [7:0]  d_buf [SER_MAX];
  logic [3:0]  d_len;
  act_t        d_act;
  logic        d_b_ack;
  logic [2:0]  d_kind;
  logic [2:0]  d_start;
  logic [8:0]  d_n;
  logic [8:0]  d_rlen;
  logic [LW-1:0] cnt_l;
  logic [31:0] hdr_addr;

  // sequencer
  ctl_t        ctl;
  stat_t       stat;
  res_t        em;
  logic        want_emit;
  logic        want_rel;
  logic        step;
  logic [7:0]  cur_byte;
  logic        ck_end;
  logic [63:0] ck_word;

  assign fire     = rx.valid && rx.ready;
  assign rx.ready = (state == S_IDLE);
  assign wr_idx   = (rx_count >= CW'(RX_STORE_BYTES)) ? '0 : rx_count[IW-1:0];
  assign ram_raddr = IW'(ck_start) + IW'(ck_pos);

  bcmd_ram #(.WIDTH(8), .DEPTH(RX_STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (fire),
    .waddr (wr_idx),
    .wdata (rx.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bcmd_out u_out (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .res_in (em),
    .stat   (stat),
    .res    (res)
  );

  assign cnt_l    = LW'(rx_count);
  assign hdr_addr = {hdr[0], hdr[1], hdr[2], hdr[3]};

  always_comb begin
    d_restart = 1'b0;
    d_to_data = 1'b0;
    d_set_cmd = 1'b0;
    for (int k = 0; k < SER_MAX; k++) begin
      d_buf[k] = 8'h00;
    end
    d_len   = 4'd0;
    d_act   = ACT_NONE;
    d_b_ack = 1'b0;
    d_kind  = K_ERASE;
    d_start = 3'd1;
    d_n     = 9'd0;
    d_rlen  = 9'd0;
    if (in_cmd) begin
      if (rx_count == CW'(1) && hdr[0] == SYNC_BYTE) begin
        d_restart = 1'b1;
        d_buf[0]  = ACK_BYTE;
        d_len     = 4'd1;
      end else if (rx_count >= CW'(2)) begin
        d_restart = 1'b1;
        d_len     = 4'd1;
        if (({1'b0, hdr[0]} + {1'b0, hdr[1]}) != 9'h0FF) begin
          d_buf[0] = NACK_BYTE;
        end else begin
          d_set_cmd = 1'b1;
          d_buf[0]  = ACK_BYTE;
          case (hdr[0])
            C_GET: begin
              d_buf[1]  = GET_COUNT;
              d_buf[2]  = version_byte;
              d_buf[3]  = C_GET;
              d_buf[4]  = C_GETV;
              d_buf[5]  = C_GETID;
              d_buf[6]  = C_READ;
              d_buf[7]  = C_GO;
              d_buf[8]  = C_WRITE;
              d_buf[9]  = C_ERASE;
              d_buf[10] = ACK_BYTE;
              d_len     = 4'd11;
            end
            C_GETV: begin
              d_buf[1] = version_byte;
              d_buf[4] = ACK_BYTE;
              d_len    = 4'd5;
            end
            C_GETID: begin
              d_buf[1] = ID_COUNT;
              d_buf[2] = product_id[15:8];
              d_buf[3] = product_id[7:0];
              d_buf[4] = ACK_BYTE;
              d_len    = 4'd5;
            end
            C_READ, C_GO, C_WRITE, C_ERASE: begin
              d_to_data = 1'b1;
            end
            default: begin
              d_buf[0] = NACK_BYTE;
            end
          endcase
        end
      end
    end else begin
      case (cmd)
        C_READ: begin
          if (rx_count == CW'(5)) begin
            d_len = 4'd1;
            if (xor0 == 8'h00) begin
              d_buf[0] = ACK_BYTE;
            end else begin
              d_buf[0]  = NACK_BYTE;
              d_restart = 1'b1;
            end
          end else if (rx_count == CW'(7)) begin
            d_restart = 1'b1;
            d_len     = 4'd1;
            if (({1'b0, hdr[5]} + {1'b0, hdr[6]}) != 9'h0FF) begin
              d_buf[0] = NACK_BYTE;
            end else begin
              d_buf[0] = ACK_BYTE;
              if (hdr[5] != 8'h00) begin
                d_act  = ACT_READ;
                d_rlen = {1'b0, hdr[5]} + 9'd1;
              end
            end
          end
        end
        C_ERASE: begin
          if (rx_count == CW'(2) && hdr[0] == ERASE_ALL) begin
            d_restart = 1'b1;
            d_act     = ACT_GLOBAL;
            d_b_ack   = 1'b1;
          end else if (cnt_l == LW'(hdr[0]) + LW'(3)) begin
            d_restart = 1'b1;
            if (xor0 == 8'h00) begin
              d_act   = ACT_CHUNK;
              d_kind  = K_ERASE;
              d_start = 3'd1;
              d_n     = {1'b0, hdr[0]} + 9'd1;
              d_b_ack = 1'b1;
            end else begin
              d_buf[0] = NACK_BYTE;
              d_len    = 4'd1;
            end
          end
        end
        C_WRITE: begin
          if (rx_count == CW'(5)) begin
            d_len = 4'd1;
            if (xor0 == 8'h00) begin
              d_buf[0] = ACK_BYTE;
            end else begin
              d_buf[0]  = NACK_BYTE;
              d_restart = 1'b1;
            end
          end else if (rx_count >= CW'(6) && cnt_l == LW'(hdr[5]) + LW'(8)) begin
            d_restart = 1'b1;
            if (xor5 == 8'h00) begin
              d_act   = ACT_CHUNK;
              d_kind  = K_WRITE;
              d_start = 3'd6;
              d_n     = {1'b0, hdr[5]} + 9'd1;
              d_b_ack = 1'b1;
            end else begin
              d_buf[0] = NACK_BYTE;
              d_len    = 4'd1;
            end
          end
        end
        C_GO: begin
          if (rx_count == CW'(5)) begin
            d_restart = 1'b1;
            d_len     = 4'd1;
            if (xor0 == 8'h00) begin
              d_buf[0] = ACK_BYTE;
              d_act    = ACT_JUMP;
            end else begin
              d_buf[0] = NACK_BYTE;
            end
          end
        end
        default: begin
          d_len = 4'd0;
        end
      endcase
    end
  end

  assign cur_byte = a_buf[a_i];
  assign ck_end   = (ck_j == 3'd7) || (ck_pos + 9'd1 == ck_n);
  assign ck_word  = ck_buf | (64'(ram_rdata) << {ck_j, 3'b000});

  always_comb begin
    want_emit = 1'b0;
    want_rel  = 1'b0;
    em        = mk_res(K_SERIAL, pend, pend_n, 32'd0, 9'd0);
    case (state)
      S_SER_A: begin
        if (a_i != a_len && pend_n == 4'd7) begin
          want_emit = 1'b1;
          em = mk_res(K_SERIAL, {cur_byte, pend[55:0]}, 4'd8, 32'd0, 9'd0);
        end
      end
      S_ACT: begin
        if (pend_n != 4'd0) begin
          want_emit = 1'b1;
        end else begin
          case (act)
            ACT_READ: begin
              want_emit = 1'b1;
              em = mk_res(K_READ, 64'd0, 4'd0, base, rd_len);
            end
            ACT_GLOBAL: begin
              want_emit = 1'b1;
              em = mk_res(K_GLOBAL, 64'd0, 4'd0, 32'd0, 9'd0);
            end
            ACT_JUMP: begin
              want_emit = 1'b1;
              em = mk_res(K_JUMP, 64'd0, 4'd0, base, 9'd0);
            end
            default: begin
              want_emit = 1'b0;
            end
          endcase
        end
      end
      S_CHK_ACC: begin
        if (ck_end) begin
          want_emit = 1'b1;
          em = mk_res(ck_kind, ck_word, {1'b0, ck_j} + 4'd1,
                      (ck_kind == K_WRITE) ? base + 32'(ck_off) : 32'd0, 9'd0);
        end
      end
      S_FIN: begin
        if (pend_n != 4'd0) begin
          want_emit = 1'b1;
        end else if (stat.hold_valid) begin
          want_rel = 1'b1;
        end
      end
      default: begin
        want_emit = 1'b0;
      end
    endcase
    step = want_emit ? stat.emit_ok : (want_rel ? stat.release_ok : 1'b1);
    ctl.emit         = want_emit && stat.emit_ok;
    ctl.release_hold = want_rel && stat.release_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rx_count     <= '0;
      in_cmd       <= 1'b1;
      cmd          <= 8'h00;
      version_byte <= 8'h10;
      product_id   <= 16'h0497;
      pend_n       <= 4'd0;
      pend         <= 64'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_VERSION) begin
          version_byte <= cfg_data[7:0];
        end else if (cfg_index == REG_PRODUCT) begin
          product_id <= cfg_data;
        end
      end
      case (state)
        S_IDLE: begin
          if (fire) begin
            rx_count <= CW'(wr_idx) + CW'(1);
            for (int k = 0; k < 7; k++) begin
              if (wr_idx == IW'(k)) begin
                hdr[k] <= rx.rx_byte;
              end
            end
            xor0 <= (wr_idx == '0) ? rx.rx_byte : (xor0 ^ rx.rx_byte);
            if (wr_idx < IW'(5)) begin
              xor5 <= 8'h00;
            end else if (wr_idx == IW'(5)) begin
              xor5 <= rx.rx_byte;
            end else begin
              xor5 <= xor5 ^ rx.rx_byte;
            end
            pend   <= 64'd0;
            pend_n <= 4'd0;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          a_buf    <= d_buf;
          a_len    <= d_len;
          a_i      <= 4'd0;
          act      <= d_act;
          b_ack    <= d_b_ack;
          ck_kind  <= d_kind;
          ck_start <= d_start;
          ck_n     <= d_n;
          rd_len   <= d_rlen;
          base     <= hdr_addr;
          if (d_set_cmd) begin
            cmd <= hdr[0];
          end
          if (d_restart) begin
            rx_count <= '0;
            in_cmd   <= !d_to_data;
          end
          state <= S_SER_A;
        end
        S_SER_A: begin
          if (a_i == a_len) begin
            state <= S_ACT;
          end else if (step) begin
            if (pend_n == 4'd7) begin
              pend   <= 64'd0;
              pend_n <= 4'd0;
            end else begin
              pend   <= pend | (64'(cur_byte) << {pend_n[2:0], 3'b000});
              pend_n <= pend_n + 4'd1;
            end
            a_i <= a_i + 4'd1;
          end
        end
        S_ACT: begin
          if (pend_n != 4'd0) begin
            if (step) begin
              pend   <= 64'd0;
              pend_n <= 4'd0;
            end
          end else begin
            case (act)
              ACT_CHUNK: begin
                ck_pos <= 9'd0;
                ck_off <= 9'd0;
                ck_j   <= 3'd0;
                ck_buf <= 64'd0;
                state  <= S_CHK_RD;
              end
              ACT_NONE: begin
                state <= S_SER_B;
              end
              default: begin
                if (step) begin
                  state <= S_SER_B;
                end
              end
            endcase
          end
        end
        S_CHK_RD: begin
          state <= S_CHK_ACC;
        end
        S_CHK_ACC: begin
          if (ck_end) begin
            if (step) begin
              ck_buf <= 64'd0;
              ck_j   <= 3'd0;
              ck_pos <= ck_pos + 9'd1;
              ck_off <= ck_pos + 9'd1;
              state  <= (ck_pos + 9'd1 == ck_n) ? S_SER_B : S_CHK_RD;
            end
          end else begin
            ck_buf <= ck_word;
            ck_j   <= ck_j + 3'd1;
            ck_pos <= ck_pos + 9'd1;
            state  <= S_CHK_RD;
          end
        end
        S_SER_B: begin
          if (b_ack) begin
            pend   <= pend | (64'(ACK_BYTE) << {pend_n[2:0], 3'b000});
            pend_n <= pend_n + 4'd1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (pend_n != 4'd0) begin
            if (step) begin
              pend   <= 64'd0;
              pend_n <= 4'd0;
            end
          end else if (step) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!stat.hold_valid && pend_n == 4'd0))
    else $error("results left over in idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CW'(RX_STORE_BYTES))
    else $error("receive count beyond store");
  a_read_before_acc: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK_ACC) |-> ($past(state) == S_CHK_RD || $past(state) == S_CHK_ACC))
    else $error("store data used without a read");
  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    pend_n <= 4'd7)
    else $error("serial packer overflow");
endmodule

@@ test/bcmd_tb_if.sv @@
`timescale 1ns / 1ps
// Channel bundles used by the testbench are the ones of the RTL; this file
// only carries a small monitor record used by the checker.
package bcmd_tb_pkg;
  import bcmd_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic [31:0] address;
    logic [8:0]  read_length;
    logic        last;
  } reply_t;
endpackage

@@ test/uart_bootloader_command_engine_checker.sv @@
`timescale 1ns / 1ps
module uart_bootloader_command_engine_checker
  import bcmd_pkg::*;
  import bcmd_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_ready,
  input  logic [7:0]  rx_byte,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [2:0]  kind,
  input  logic [63:0] payload,
  input  logic [3:0]  byte_count,
  input  logic [31:0] address,
  input  logic [8:0]  read_length,
  input  logic        last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_total
);

  localparam int STORE_BYTES = 512;

  logic [7:0]  store [STORE_BYTES];
  int unsigned fill;
  logic        cmd_phase;
  logic [7:0]  cur_cmd;
  logic [7:0]  version;
  logic [15:0] product;

  reply_t expected_replies[$];
  reply_t step_out[$];
  logic [63:0] ser_bits;
  int unsigned ser_n;

  function automatic logic [7:0] sb(int unsigned i);
    return (i < STORE_BYTES) ? store[i] : 8'h00;
  endfunction

  function automatic logic [31:0] addr_be();
    return {sb(0), sb(1), sb(2), sb(3)};
  endfunction

  function automatic logic xor_zero(int unsigned start, int unsigned len);
    logic [7:0] x;
    x = 8'h00;
    for (int unsigned i = 0; i < len; i++) x ^= sb(start + i);
    return x == 8'h00;
  endfunction

  task automatic push(logic [2:0] k, logic [63:0] p, logic [3:0] c, logic [31:0] a,
                      logic [8:0] rl);
    reply_t r;
    if (step_out.size() >= 33) return;
    r.kind = k;
    r.payload = p;
    r.byte_count = c;
    r.address = a;
    r.read_length = rl;
    r.last = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic flush_serial();
    if (ser_n > 0) push(K_SERIAL, ser_bits, 4'(ser_n), 32'h0, 9'h0);
    ser_bits = '0;
    ser_n = 0;
  endtask

  task automatic send(logic [7:0] b);
    ser_bits |= 64'(b) << (8 * ser_n);
    ser_n++;
    if (ser_n == 8) flush_serial();
  endtask

  task automatic restart();
    cmd_phase = 1'b1;
    fill = 0;
  endtask

  task automatic emit_chunks(logic [2:0] k, int unsigned base, int unsigned n, logic use_addr);
    logic [63:0] p;
    int unsigned j;
    for (int unsigned off = 0; off < n; off += 8) begin
      p = '0;
      for (j = 0; j < 8 && off + j < n; j++) p |= 64'(sb(base + off + j)) << (8 * j);
      push(k, p, 4'(j), use_addr ? addr_be() + 32'(off) : 32'h0, 9'h0);
    end
  endtask

  task automatic command_step();
    logic ok;
    if (fill == 1 && sb(0) == SYNC_BYTE) begin
      restart();
      send(ACK_BYTE);
      return;
    end
    if (fill < 2) return;
    if (9'(sb(0)) + 9'(sb(1)) != 9'h0FF) begin
      restart();
      send(NACK_BYTE);
      return;
    end
    cur_cmd = sb(0);
    ok = cur_cmd inside {C_GET, C_GETV, C_GETID, C_READ, C_GO, C_WRITE, C_ERASE};
    restart();
    send(ok ? ACK_BYTE : NACK_BYTE);
    if (!ok) return;
    case (cur_cmd)
      C_GET: begin
        send(GET_COUNT); send(version);
        send(C_GET); send(C_GETV); send(C_GETID); send(C_READ);
        send(C_GO); send(C_WRITE); send(C_ERASE); send(ACK_BYTE);
      end
      C_GETV: begin
        send(version); send(8'h00); send(8'h00); send(ACK_BYTE);
      end
      C_GETID: begin
        send(ID_COUNT); send(product[15:8]); send(product[7:0]); send(ACK_BYTE);
      end
      default: cmd_phase = 1'b0;
    endcase
  endtask

  task automatic data_step();
    int unsigned n;
    case (cur_cmd)
      C_READ: begin
        if (fill == 5) begin
          if (xor_zero(0, 5)) send(ACK_BYTE);
          else begin send(NACK_BYTE); restart(); end
        end else if (fill == 7) begin
          if (9'(sb(5)) + 9'(sb(6)) != 9'h0FF) send(NACK_BYTE);
          else begin
            send(ACK_BYTE);
            if (sb(5) > 0) begin
              flush_serial();
              push(K_READ, '0, 4'h0, addr_be(), 9'(sb(5)) + 9'h1);
            end
          end
          restart();
        end
      end
      C_ERASE: begin
        if (fill == 2 && sb(0) == ERASE_ALL) begin
          flush_serial();
          push(K_GLOBAL, '0, 4'h0, 32'h0, 9'h0);
          send(ACK_BYTE);
          restart();
        end else if (fill == sb(0) + 3) begin
          n = sb(0) + 1;
          if (xor_zero(0, n + 2)) begin
            flush_serial();
            emit_chunks(K_ERASE, 1, n, 1'b0);
            send(ACK_BYTE);
          end else send(NACK_BYTE);
          restart();
        end
      end
      C_WRITE: begin
        if (fill == 5) begin
          if (xor_zero(0, 5)) send(ACK_BYTE);
          else begin send(NACK_BYTE); restart(); end
        end else if (fill >= 6 && fill == sb(5) + 8) begin
          n = sb(5) + 1;
          if (xor_zero(5, n + 2)) begin
            flush_serial();
            emit_chunks(K_WRITE, 6, n, 1'b1);
            send(ACK_BYTE);
          end else send(NACK_BYTE);
          restart();
        end
      end
      C_GO: begin
        if (fill == 5) begin
          if (xor_zero(0, 5)) begin
            send(ACK_BYTE);
            flush_serial();
            push(K_JUMP, '0, 4'h0, addr_be(), 9'h0);
          end else send(NACK_BYTE);
          restart();
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(logic [7:0] b);
    step_out.delete();
    ser_bits = '0;
    ser_n = 0;
    if (fill >= STORE_BYTES) fill = 0;
    store[fill] = b;
    fill++;
    if (cmd_phase) command_step();
    else data_step();
    flush_serial();
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) expected_replies.push_back(step_out[i]);
  endtask

  task automatic check_reply();
    reply_t e;
    if (expected_replies.size() == 0) begin
      $error("unexpected result kind=%0d payload=%h", kind, payload);
      fail_count++;
      return;
    end
    e = expected_replies.pop_front();
    if (kind !== e.kind) begin
      $error("kind exp %0d got %0d", e.kind, kind); fail_count++;
    end
    if (payload !== e.payload) begin
      $error("payload exp %h got %h", e.payload, payload); fail_count++;
    end
    if (byte_count !== e.byte_count) begin
      $error("byte_count exp %0d got %0d", e.byte_count, byte_count); fail_count++;
    end
    if (address !== e.address) begin
      $error("address exp %h got %h", e.address, address); fail_count++;
    end
    if (read_length !== e.read_length) begin
      $error("read_length exp %0d got %0d", e.read_length, read_length); fail_count++;
    end
    if (last !== e.last) begin
      $error("last exp %0d got %0d", e.last, last); fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    result_total = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      foreach (store[i]) store[i] = 8'h00;
      fill = 0;
      cmd_phase = 1'b1;
      cur_cmd = 8'h00;
      version = 8'h10;
      product = 16'h0497;
      expected_replies.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_VERSION) version = cfg_data[7:0];
        else if (cfg_index == REG_PRODUCT) product = cfg_data;
      end
      if (res_valid && res_ready) begin
        check_reply();
        result_total++;
      end
      if (rx_valid && rx_ready) predict_byte(rx_byte);
    end
    pending = expected_replies.size();
  end

endmodule

@@ test/uart_bootloader_command_engine_tb.sv @@
`timescale 1ns / 1ps
module uart_bootloader_command_engine_tb;
  import bcmd_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          result_total;
  int          sent_bytes;
  int          idle_cycles;
  logic        hold_sink;
  logic [7:0]  seq[$];

  bcmd_rx_if  rx ();
  bcmd_res_if res ();

  uart_bootloader_command_engine dut (
    .clk(clk), .rst(rst), .rx(rx.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  uart_bootloader_command_engine_checker chk (
    .clk(clk), .rst(rst),
    .rx_valid(rx.valid), .rx_ready(rx.ready), .rx_byte(rx.rx_byte),
    .res_valid(res.valid), .res_ready(res.ready), .kind(res.kind),
    .payload(res.payload), .byte_count(res.byte_count), .address(res.address),
    .read_length(res.read_length), .last(res.last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .result_total(result_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result sink: random stalls, plus one long hold-off
  initial begin
    int wait_n;
    res.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        res.ready = 1'b0;
      end else begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (wait_n > 0) begin
          res.ready = 1'b0;
          repeat (wait_n - 1) @(negedge clk);
          @(negedge clk);
        end
        res.ready = 1'b1;
        @(posedge clk);
        while (!res.valid) @(posedge clk);
      end
    end
  end

  // long hold-off while random traffic keeps coming
  initial begin
    @(negedge rst);
    wait (sent_bytes >= 150);
    hold_sink = 1'b1;
    repeat (600) @(posedge clk);
    hold_sink = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    repeat (gap) @(negedge clk);
    rx.valid = 1'b1;
    rx.rx_byte = b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    @(negedge clk);
    rx.valid = 1'b0;
    rx.rx_byte = 8'($urandom);
    sent_bytes++;
  endtask

  task automatic send_seq();
    while (seq.size() > 0) send_byte(seq.pop_front());
  endtask

  task automatic add_cmd(logic [7:0] c);
    seq.push_back(c);
    seq.push_back(~c);
  endtask

  task automatic add_addr(logic [31:0] a, logic corrupt);
    seq.push_back(a[31:24]); seq.push_back(a[23:16]);
    seq.push_back(a[15:8]);  seq.push_back(a[7:0]);
    seq.push_back(a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0] ^ (corrupt ? 8'h01 : 8'h00));
  endtask

  task automatic add_write(logic [31:0] a, logic [7:0] n, logic corrupt);
    logic [7:0] x;
    add_cmd(C_WRITE);
    add_addr(a, 1'b0);
    seq.push_back(n);
    x = n;
    for (int i = 0; i <= n; i++) begin
      seq.push_back(8'($urandom));
      x ^= seq[seq.size() - 1];
    end
    seq.push_back(x ^ (corrupt ? 8'h80 : 8'h00));
  endtask

  task automatic add_erase(logic [7:0] n, logic corrupt);
    logic [7:0] x;
    add_cmd(C_ERASE);
    seq.push_back(n);
    x = n;
    for (int i = 0; i <= n; i++) begin
      seq.push_back(8'($urandom));
      x ^= seq[seq.size() - 1];
    end
    seq.push_back(x ^ (corrupt ? 8'h02 : 8'h00));
  endtask

  task automatic add_read(logic [31:0] a, logic [7:0] n, logic corrupt);
    add_cmd(C_READ);
    add_addr(a, 1'b0);
    seq.push_back(n);
    seq.push_back(~n ^ (corrupt ? 8'h04 : 8'h00));
  endtask

  task automatic add_random_seq();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0: seq.push_back(SYNC_BYTE);
      1: add_cmd(C_GET);
      2: add_cmd(C_GETV);
      3: add_cmd(C_GETID);
      4: add_read(32'($urandom), 8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      5: begin
        add_cmd(C_GO);
        add_addr(32'($urandom), $urandom_range(0, 4) == 0);
      end
      6, 7: add_write(32'($urandom), 8'($urandom_range(0, 20)), $urandom_range(0, 5) == 0);
      8: add_erase(8'($urandom_range(0, 12)), $urandom_range(0, 5) == 0);
      9: begin
        add_cmd(C_ERASE);
        seq.push_back(ERASE_ALL);
        seq.push_back(8'($urandom));
      end
      10: begin
        c = 8'($urandom);
        seq.push_back(c);
        seq.push_back($urandom_range(0, 1) ? ~c : 8'($urandom));
      end
      default: begin
        add_cmd(C_READ);
        add_addr(32'($urandom), 1'b1);
      end
    endcase
  endtask

  task automatic quiesce();
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_index = 8'h00;
    cfg_data = 16'h0000;
    sent_bytes = 0;
    hold_sink = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: default registers, then each command and special case
    seq.push_back(SYNC_BYTE);
    add_cmd(C_GET);
    add_cmd(C_GETID);
    add_read(32'hFFFF_FFFF, 8'h00, 1'b0);
    send_seq();
    quiesce();
    write_reg(REG_VERSION, 16'h00FF);
    write_reg(REG_PRODUCT, 16'hFFFF);
    add_cmd(C_GETV);
    add_cmd(C_GETID);
    add_read(32'h0000_0000, 8'hFF, 1'b0);
    send_seq();
    add_write(32'hFFFF_FFFC, 8'h28, 1'b0);
    add_erase(8'h11, 1'b0);
    add_cmd(C_ERASE);
    seq.push_back(ERASE_ALL);
    seq.push_back(8'h00);
    seq.push_back(8'h55);
    seq.push_back(8'h12);
    seq.push_back(8'h12);
    add_cmd(8'h5A);
    add_cmd(C_GO);
    add_addr(32'h0800_0000, 1'b0);
    send_seq();
    quiesce();
    write_reg(REG_VERSION, 16'h0000);
    write_reg(REG_PRODUCT, 16'h0000);
    write_reg(8'hFF, 16'hA5A5);
    add_cmd(C_GET);
    add_cmd(C_GETID);
    send_seq();

    for (int phase = 0; phase < 3; phase++) begin
      quiesce();
      write_reg(REG_VERSION, 16'($urandom_range(0, 255)));
      write_reg(REG_PRODUCT, 16'($urandom));
      while (sent_bytes < 170 + phase * 50) begin
        add_random_seq();
        send_seq();
      end
    end
    quiesce();
    $display("Sent %0d bytes over directed commands, random command streams and",
             sent_bytes);
    $display("several register settings; %0d results checked.", result_total);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
